// File: design/lnf_pkg.sv
package lnf_pkg;

  localparam int NUM_DIRS = 26;
  localparam int MASK_BITS = 64;

  // Position of a candidate cell along one axis, relative to the node.
  localparam logic [1:0] IDX_NEG = 2'd0;
  localparam logic [1:0] IDX_MID = 2'd1;
  localparam logic [1:0] IDX_POS = 2'd2;

  localparam logic signed [1:0] OFF_ZERO = 2'sb00;
  localparam logic signed [1:0] OFF_POS  = 2'sb01;
  localparam logic signed [1:0] OFF_NEG  = 2'sb11;

  typedef enum logic [1:0] {
    REG_EXTENT_X = 2'd0,
    REG_EXTENT_Y = 2'd1,
    REG_EXTENT_Z = 2'd2
  } lnf_reg_e;

  typedef struct packed {
    logic              found;
    logic signed [1:0] off_x;
    logic signed [1:0] off_y;
    logic signed [1:0] off_z;
  } lnf_sel_t;

  // Candidate directions in priority order: W, E, S, N, B, T, NW, NE, SW, SE,
  // BW, BE, BS, BN, TW, TE, TS, TN, TNW, TNE, TSE, TSW, BNW, BNE, BSE, BSW.
  localparam logic [1:0] DIR_IX [NUM_DIRS] = '{
    2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd0, 2'd2, 2'd0, 2'd2,
    2'd0, 2'd2, 2'd1, 2'd1,
    2'd0, 2'd2, 2'd1, 2'd1,
    2'd0, 2'd2, 2'd2, 2'd0,
    2'd0, 2'd2, 2'd2, 2'd0
  };

  localparam logic [1:0] DIR_IY [NUM_DIRS] = '{
    2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd0, 2'd0,
    2'd1, 2'd1, 2'd0, 2'd2,
    2'd1, 2'd1, 2'd0, 2'd2,
    2'd2, 2'd2, 2'd0, 2'd0,
    2'd2, 2'd2, 2'd0, 2'd0
  };

  localparam logic [1:0] DIR_IZ [NUM_DIRS] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2,
    2'd1, 2'd1, 2'd1, 2'd1,
    2'd0, 2'd0, 2'd0, 2'd0,
    2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2,
    2'd0, 2'd0, 2'd0, 2'd0
  };

  // Bits of the neighbourhood mask covered by the 2x2x2 cell with base (bx, by, bz).
  function automatic logic [MASK_BITS-1:0] cell_mask(logic [1:0] bx, logic [1:0] by,
                                                      logic [1:0] bz);
    logic [MASK_BITS-1:0] m;
    logic [5:0]           bit_idx;
    m = '0;
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          bit_idx = {bz + 2'(k), by + 2'(j), bx + 2'(i)};
          m[bit_idx] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // A cell on the negative side gives a positive offset, and the reverse.
  function automatic logic signed [1:0] idx_to_off(logic [1:0] idx);
    logic signed [1:0] off;
    case (idx)
      IDX_NEG: off = OFF_POS;
      IDX_POS: off = OFF_NEG;
      default: off = OFF_ZERO;
    endcase
    return off;
  endfunction

endpackage

// File: design/lattice_neighbor_cell_finder_unit.sv
// Neighbour cell finder: a request (node coordinates and the solid mask of its
// 4x4x4 neighbourhood) is accepted on any clock edge with start_i high, since
// busy_o never rises, so one request per cycle is sustained. The request passes
// through an input register and a result register, and its result appears on
// the result ports with done_o high for exactly one cycle, in request order. The
// receiver cannot stall the result, so it must take it in that cycle. Grid
// extents sit at APB byte addresses 0, 4 and 8 (x, y, z), reset to
// 2**COORD_BITS, and should only be written while no request is in flight.
module lattice_neighbor_cell_finder_unit #(
  parameter int COORD_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [COORD_BITS-1:0]          node_x_i,
  input  logic [COORD_BITS-1:0]          node_y_i,
  input  logic [COORD_BITS-1:0]          node_z_i,
  input  logic [lnf_pkg::MASK_BITS-1:0]  solid_mask_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic signed [1:0]              offset_x_o,
  output logic signed [1:0]              offset_y_o,
  output logic signed [1:0]              offset_z_o,
  output logic [COORD_BITS-1:0]          cell_x_o,
  output logic [COORD_BITS-1:0]          cell_y_o,
  output logic [COORD_BITS-1:0]          cell_z_o
);
  import lnf_pkg::*;

  logic [COORD_BITS:0]     extent_x, extent_y, extent_z;
  logic                    in_valid_q;
  logic [COORD_BITS-1:0]   node_x_q, node_y_q, node_z_q;
  logic [MASK_BITS-1:0]    mask_q;
  logic [2:0]              ok_x, ok_y, ok_z;
  lnf_sel_t                sel;
  logic                    done_q;
  logic                    found_q;
  logic signed [1:0]       off_x_q, off_y_q, off_z_q;
  logic [COORD_BITS-1:0]   cell_x_q, cell_y_q, cell_z_q;
  logic [COORD_BITS-1:0]   cell_x_d, cell_y_d, cell_z_d;

  function automatic logic [COORD_BITS-1:0] cell_coord(logic [COORD_BITS-1:0] n,
                                                        logic signed [1:0] off);
    logic [COORD_BITS-1:0] c;
    case (off)
      OFF_POS: c = n - COORD_BITS'(1);
      OFF_NEG: c = n + COORD_BITS'(1);
      default: c = n;
    endcase
    return c;
  endfunction

  lnf_cfg_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .extent_x_o (extent_x),
    .extent_y_o (extent_y),
    .extent_z_o (extent_z)
  );

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start_i;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    node_x_q <= node_x_i;
    node_y_q <= node_y_i;
    node_z_q <= node_z_i;
    mask_q   <= solid_mask_i;
  end

  lnf_axis_check #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .node_i   (node_x_q),
    .extent_i (extent_x),
    .ok_o     (ok_x)
  );

  lnf_axis_check #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .node_i   (node_y_q),
    .extent_i (extent_y),
    .ok_o     (ok_y)
  );

  lnf_axis_check #(.COORD_BITS(COORD_BITS)) u_axis_z (
    .node_i   (node_z_q),
    .extent_i (extent_z),
    .ok_o     (ok_z)
  );

  lnf_dir_select u_dir_select (
    .ok_x_i (ok_x),
    .ok_y_i (ok_y),
    .ok_z_i (ok_z),
    .mask_i (mask_q),
    .sel_o  (sel)
  );

  always_comb begin
    cell_x_d = sel.found ? cell_coord(node_x_q, sel.off_x) : '0;
    cell_y_d = sel.found ? cell_coord(node_y_q, sel.off_y) : '0;
    cell_z_d = sel.found ? cell_coord(node_z_q, sel.off_z) : '0;
  end

  always_ff @(posedge clk_i) begin
    found_q  <= sel.found;
    off_x_q  <= sel.off_x;
    off_y_q  <= sel.off_y;
    off_z_q  <= sel.off_z;
    cell_x_q <= cell_x_d;
    cell_y_q <= cell_y_d;
    cell_z_q <= cell_z_d;
  end

  assign done_o     = done_q;
  assign found_o    = found_q;
  assign offset_x_o = off_x_q;
  assign offset_y_o = off_y_q;
  assign offset_z_o = off_z_q;
  assign cell_x_o   = cell_x_q;
  assign cell_y_o   = cell_y_q;
  assign cell_z_o   = cell_z_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result strobe without a matching request");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (offset_x_o == OFF_ZERO && offset_y_o == OFF_ZERO &&
                              offset_z_o == OFF_ZERO && cell_x_o == '0 &&
                              cell_y_o == '0 && cell_z_o == '0))
    else $error("result fields not cleared when no cell was found");

  a_hit_has_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> !(offset_x_o == OFF_ZERO && offset_y_o == OFF_ZERO &&
                              offset_z_o == OFF_ZERO))
    else $error("found cell without a direction");

  a_cell_x_west: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o && offset_x_o == OFF_POS) |->
      ((cell_x_o + COORD_BITS'(1)) == $past(node_x_i, 2)))
    else $error("cell origin x does not match the node and offset");

endmodule

// File: design/lnf_cfg_regs.sv
module lnf_cfg_regs #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [COORD_BITS:0]   extent_x_o,
  output logic [COORD_BITS:0]   extent_y_o,
  output logic [COORD_BITS:0]   extent_z_o
);
  import lnf_pkg::*;

  localparam logic [COORD_BITS:0] ExtentReset = {1'b1, {COORD_BITS{1'b0}}};

  logic [COORD_BITS:0] extent_x_q, extent_y_q, extent_z_q;
  logic [COORD_BITS:0] extent_x_d, extent_y_d, extent_z_d;
  logic                wr_en;
  logic [COORD_BITS:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    extent_x_d = extent_x_q;
    extent_y_d = extent_y_q;
    extent_z_d = extent_z_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_EXTENT_X: extent_x_d = pwdata[COORD_BITS:0];
        REG_EXTENT_Y: extent_y_d = pwdata[COORD_BITS:0];
        REG_EXTENT_Z: extent_z_d = pwdata[COORD_BITS:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_x_q <= ExtentReset;
      extent_y_q <= ExtentReset;
      extent_z_q <= ExtentReset;
    end else begin
      extent_x_q <= extent_x_d;
      extent_y_q <= extent_y_d;
      extent_z_q <= extent_z_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EXTENT_X: rd_val = extent_x_q;
      REG_EXTENT_Y: rd_val = extent_y_q;
      REG_EXTENT_Z: rd_val = extent_z_q;
      default:      rd_val = '0;
    endcase
  end

  assign prdata     = 32'(rd_val);
  assign extent_x_o = extent_x_q;
  assign extent_y_o = extent_y_q;
  assign extent_z_o = extent_z_q;

endmodule

// File: design/lnf_axis_check.sv
module lnf_axis_check #(
  parameter int COORD_BITS = 10
) (
  input  logic [COORD_BITS-1:0] node_i,
  input  logic [COORD_BITS:0]   extent_i,
  output logic [2:0]            ok_o
);
  import lnf_pkg::*;

  localparam int W = COORD_BITS + 2;

  logic [W-1:0] node_w;
  logic [W-1:0] ext_w;

  assign node_w = {2'b00, node_i};
  assign ext_w  = {1'b0, extent_i};

  // The corner tested is node - 1, node or node + 2, depending on the side.
  assign ok_o[IDX_NEG] = (node_i != '0) && ((node_w - W'(1)) < ext_w);
  assign ok_o[IDX_MID] = node_w < ext_w;
  assign ok_o[IDX_POS] = (node_w + W'(2)) < ext_w;

endmodule

// File: design/lnf_dir_select.sv
module lnf_dir_select (
  input  logic [2:0]                  ok_x_i,
  input  logic [2:0]                  ok_y_i,
  input  logic [2:0]                  ok_z_i,
  input  logic [lnf_pkg::MASK_BITS-1:0] mask_i,
  output lnf_pkg::lnf_sel_t           sel_o
);
  import lnf_pkg::*;

  logic [NUM_DIRS-1:0] cand;

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      cand[d] = ok_x_i[DIR_IX[d]] && ok_y_i[DIR_IY[d]] && ok_z_i[DIR_IZ[d]] &&
                !(|(mask_i & cell_mask(DIR_IX[d], DIR_IY[d], DIR_IZ[d])));
    end
  end

  // The first usable direction in priority order wins.
  always_comb begin
    sel_o = '0;
    for (int d = NUM_DIRS - 1; d >= 0; d--) begin
      if (cand[d]) begin
        sel_o.found = 1'b1;
        sel_o.off_x = idx_to_off(DIR_IX[d]);
        sel_o.off_y = idx_to_off(DIR_IY[d]);
        sel_o.off_z = idx_to_off(DIR_IZ[d]);
      end
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import lnf_pkg::*;

  localparam int COORD_BITS  = 10;
  localparam int CYCLE_LIMIT = 200000;

  // Cell step per axis for each direction, in the order the block tries them.
  localparam int STEP_X [NUM_DIRS] = '{
    -1, 1, 0, 0, 0, 0, -1, 1, -1, 1, -1, 1, 0, 0,
    -1, 1, 0, 0, -1, 1, 1, -1, -1, 1, 1, -1
  };
  localparam int STEP_Y [NUM_DIRS] = '{
    0, 0, -1, 1, 0, 0, 1, 1, -1, -1, 0, 0, -1, 1,
    0, 0, -1, 1, 1, 1, -1, -1, 1, 1, -1, -1
  };
  localparam int STEP_Z [NUM_DIRS] = '{
    0, 0, 0, 0, -1, 1, 0, 0, 0, 0, -1, -1, -1, -1,
    1, 1, 1, 1, 1, 1, 1, 1, -1, -1, -1, -1
  };

  typedef struct packed {
    logic                  found;
    logic signed [1:0]     off_x;
    logic signed [1:0]     off_y;
    logic signed [1:0]     off_z;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [COORD_BITS-1:0] cell_z;
  } cell_result_t;

  class cell_board;
    logic [COORD_BITS:0] ext_x;
    logic [COORD_BITS:0] ext_y;
    logic [COORD_BITS:0] ext_z;
    cell_result_t        pending_cells[$];
    int                  mismatches;

    function new();
      ext_x = 11'd1024;
      ext_y = 11'd1024;
      ext_z = 11'd1024;
      mismatches = 0;
    endfunction

    function void set_extent(lnf_reg_e r, logic [COORD_BITS:0] v);
      case (r)
        REG_EXTENT_X: ext_x = v;
        REG_EXTENT_Y: ext_y = v;
        REG_EXTENT_Z: ext_z = v;
        default: ;
      endcase
    endfunction

    function logic [MASK_BITS-1:0] cell_bits(int d);
      logic [MASK_BITS-1:0] bits;
      int bx, by, bz;
      bits = '0;
      bx = STEP_X[d] + 1;
      by = STEP_Y[d] + 1;
      bz = STEP_Z[d] + 1;
      for (int k = 0; k < 2; k++)
        for (int j = 0; j < 2; j++)
          for (int i = 0; i < 2; i++)
            bits[(bz + k) * 16 + (by + j) * 4 + (bx + i)] = 1'b1;
      return bits;
    endfunction

    // Only the far corner of the cell along each axis is tested against the extent.
    function bit axis_clear(int n, int step, logic [COORD_BITS:0] ext);
      int c;
      c = n + ((step < 0) ? -1 : ((step > 0) ? 2 : 0));
      return (c >= 0) && (c < int'(ext));
    endfunction

    function cell_result_t find_cell(int x, int y, int z, logic [MASK_BITS-1:0] m);
      cell_result_t r;
      r = '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
        if (axis_clear(x, STEP_X[d], ext_x) && axis_clear(y, STEP_Y[d], ext_y) &&
            axis_clear(z, STEP_Z[d], ext_z) && ((m & cell_bits(d)) == '0)) begin
          r.found  = 1'b1;
          r.off_x  = 2'(-STEP_X[d]);
          r.off_y  = 2'(-STEP_Y[d]);
          r.off_z  = 2'(-STEP_Z[d]);
          r.cell_x = COORD_BITS'(x + STEP_X[d]);
          r.cell_y = COORD_BITS'(y + STEP_Y[d]);
          r.cell_z = COORD_BITS'(z + STEP_Z[d]);
          return r;
        end
      end
      return r;
    endfunction

    function void note_request(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                               logic [COORD_BITS-1:0] z, logic [MASK_BITS-1:0] m);
      pending_cells.push_back(find_cell(int'(x), int'(y), int'(z), m));
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (pending_cells.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request outstanding: found=%0d cell=(%0d,%0d,%0d)",
                   $time, got.found, got.cell_x, got.cell_y, got.cell_z);
        mismatches++;
        return;
      end
      want = pending_cells.pop_front();
      if (got.found !== want.found || got.off_x !== want.off_x ||
          got.off_y !== want.off_y || got.off_z !== want.off_z ||
          got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
          got.cell_z !== want.cell_z) begin
        if (mismatches < 10) begin
          $display("%0t: expected found=%0d off=(%0d,%0d,%0d) cell=(%0d,%0d,%0d)",
                   $time, want.found, want.off_x, want.off_y, want.off_z,
                   want.cell_x, want.cell_y, want.cell_z);
          $display("%0t: actual   found=%0d off=(%0d,%0d,%0d) cell=(%0d,%0d,%0d)",
                   $time, got.found, got.off_x, got.off_y, got.off_z,
                   got.cell_x, got.cell_y, got.cell_z);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_cells.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [3:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [COORD_BITS-1:0] node_x_i = '0;
  logic [COORD_BITS-1:0] node_y_i = '0;
  logic [COORD_BITS-1:0] node_z_i = '0;
  logic [MASK_BITS-1:0]  solid_mask_i = '0;
  logic                  done_o;
  logic                  found_o;
  logic signed [1:0]     offset_x_o;
  logic signed [1:0]     offset_y_o;
  logic signed [1:0]     offset_z_o;
  logic [COORD_BITS-1:0] cell_x_o;
  logic [COORD_BITS-1:0] cell_y_o;
  logic [COORD_BITS-1:0] cell_z_o;

  cell_board board;
  int        cycle_count = 0;

  lattice_neighbor_cell_finder_unit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .node_x_i    (node_x_i),
    .node_y_i    (node_y_i),
    .node_z_i    (node_z_i),
    .solid_mask_i(solid_mask_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .offset_x_o  (offset_x_o),
    .offset_y_o  (offset_y_o),
    .offset_z_o  (offset_z_o),
    .cell_x_o    (cell_x_o),
    .cell_y_o    (cell_y_o),
    .cell_z_o    (cell_z_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cell_result_t seen;
    if (rst_ni) begin
      if (start_i && !busy_o)
        board.note_request(node_x_i, node_y_i, node_z_i, solid_mask_i);
      if (done_o) begin
        seen.found  = found_o;
        seen.off_x  = offset_x_o;
        seen.off_y  = offset_y_o;
        seen.off_z  = offset_z_o;
        seen.cell_x = cell_x_o;
        seen.cell_y = cell_y_o;
        seen.cell_z = cell_z_o;
        board.check_result(seen);
      end
    end
  end

  task automatic drive_node(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            logic [COORD_BITS-1:0] z, logic [MASK_BITS-1:0] m);
    start_i      <= 1'b1;
    node_x_i     <= x;
    node_y_i     <= y;
    node_z_i     <= z;
    solid_mask_i <= m;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic pause_sender(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic apb_write(lnf_reg_e r, logic [COORD_BITS:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_extent(r, v);
  endtask

  // The extents may only change once every request has produced its result.
  task automatic write_extents(int x, int y, int z);
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    apb_write(REG_EXTENT_X, 11'(x));
    apb_write(REG_EXTENT_Y, 11'(y));
    apb_write(REG_EXTENT_Z, 11'(z));
  endtask

  // Coordinates cluster at the grid edges and inside the extent, where the bounds
  // check decides between directions.
  function automatic logic [COORD_BITS-1:0] pick_coord(int ext);
    int hi, v;
    hi = (ext + 2 > 1023) ? 1023 : ext + 2;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 1023));
      1: begin
        case ($urandom_range(0, 2))
          0: v = int'($urandom_range(0, 2));
          1: v = ext - int'($urandom_range(0, 3));
          default: v = 1023 - int'($urandom_range(0, 2));
        endcase
      end
      default: v = int'($urandom_range(0, hi));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return COORD_BITS'(v);
  endfunction

  // Many masks leave one chosen cell open so that every direction gets picked.
  function automatic logic [MASK_BITS-1:0] make_mask();
    logic [MASK_BITS-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return a;
      1: return a | b | c;
      2, 3: return ~board.cell_bits($urandom_range(0, NUM_DIRS - 1)) & ~(a & b & c);
      4: return a & b;
      default: begin
        case ($urandom_range(0, 2))
          0: return '1;
          1: return '0;
          default: return ~board.cell_bits($urandom_range(0, NUM_DIRS - 1));
        endcase
      end
    endcase
  endfunction

  task automatic run_phase(int count, bit may_idle);
    bit calm;
    calm = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (may_idle) begin
        if (i % 32 == 0)
          calm = ($urandom_range(0, 2) == 0);
        if (!calm && $urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 8));
      end
      drive_node(pick_coord(int'(board.ext_x)), pick_coord(int'(board.ext_y)),
                 pick_coord(int'(board.ext_z)), make_mask());
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    drive_node(10'd500, 10'd500, 10'd500, '0);
    drive_node(10'd500, 10'd500, 10'd500, '1);
    drive_node(10'd0, 10'd0, 10'd0, '0);
    drive_node(10'd1023, 10'd1023, 10'd1023, '0);
    drive_node(10'd1023, 10'd1023, 10'd1023, ~board.cell_bits(0));
    drive_node(10'd1023, 10'd0, 10'd512, ~board.cell_bits(1));
    drive_node(10'd0, 10'd1023, 10'd0, ~64'h1);
    drive_node(10'h2AA, 10'h155, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_node(10'h155, 10'h2AA, 10'h155, 64'h5555_5555_5555_5555);
    for (int d = 0; d < NUM_DIRS; d += 3)
      drive_node(10'd500, 10'd500, 10'd500, ~board.cell_bits(d));
    run_phase(200, 1'b1);

    write_extents(1, 1, 1);
    run_phase(215, 1'b1);

    // With extents above the coordinate range a cell origin wraps around.
    write_extents(2047, 2047, 2047);
    drive_node(10'd1023, 10'd1023, 10'd1023, ~board.cell_bits(1));
    drive_node(10'd1023, 10'd1023, 10'd1023, ~board.cell_bits(19));
    run_phase(215, 1'b1);

    write_extents(0, 1024, 5);
    run_phase(215, 1'b1);

    write_extents($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 8));
    run_phase(215, 1'b1);

    write_extents($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 1024));
    run_phase(215, 1'b1);

    write_extents(1024, 2, 1023);
    run_phase(215, 1'b1);

    write_extents(1024, 1024, 1024);
    run_phase(240, 1'b0);

    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: lattice_neighbor_cell_finder_unit.f
design/lnf_pkg.sv
design/lnf_cfg_regs.sv
design/lnf_axis_check.sv
design/lnf_dir_select.sv
design/lattice_neighbor_cell_finder_unit.sv
sim/tb_top.sv
